// ----- design/gfve_pkg.sv -----
package gfve_pkg;

	// Default width of the elapsed time actually used
	localparam int GFVE_MS_BITS = 16;

	// Width of the largest power of ten for a position precision
	localparam int POW10_W = 30;
	// Width of millimetres per degree times the velocity scale
	localparam int KCONST_W = 37;
	// Numerator: 32-bit magnitude times the 37-bit constant
	localparam int NUM_W = 32 + KCONST_W;
	// Quotient bits kept below the overflow bit
	localparam int QUOT_W = 15;

	// Configuration register indexes
	localparam logic [1:0] REG_LAT_PREC = 2'd0;
	localparam logic [1:0] REG_LON_PREC = 2'd1;
	localparam logic [1:0] REG_VEL_PREC = 2'd2;
	localparam logic [1:0] REG_VEL_LIMIT = 2'd3;

	// Arithmetic unit operations
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_DEN = 3'd1;
	localparam logic [2:0] OP_MLO = 3'd2;
	localparam logic [2:0] OP_MHI = 3'd3;
	localparam logic [2:0] OP_DIV = 3'd4;

	typedef struct packed {
		logic               kind;
		logic [15:0]        elapsed_ms;
		logic signed [31:0] latitude_raw;
		logic signed [31:0] longitude_raw;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] north_velocity;
		logic signed [15:0] east_velocity;
		logic               rejected;
		logic               reference_taken;
	} out_item_t;

	// Command from the sequencer to the arithmetic unit
	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  step;
		logic [31:0] mag;
		logic [3:0]  prec;
		logic [1:0]  vel_prec;
	} arith_ctrl_t;

	// Ten to the position precision, saturating at nine places
	function automatic logic [POW10_W-1:0] gfve_pow10(input logic [3:0] prec);
		logic [POW10_W-1:0] val;
		case (prec)
			4'd0: val = POW10_W'(1);
			4'd1: val = POW10_W'(10);
			4'd2: val = POW10_W'(100);
			4'd3: val = POW10_W'(1000);
			4'd4: val = POW10_W'(10000);
			4'd5: val = POW10_W'(100000);
			4'd6: val = POW10_W'(1000000);
			4'd7: val = POW10_W'(10000000);
			4'd8: val = POW10_W'(100000000);
			default: val = POW10_W'(1000000000);
		endcase
		return val;
	endfunction

	// Millimetres per degree on a 6371 km sphere, times ten to the velocity precision
	function automatic logic [KCONST_W-1:0] gfve_kconst(input logic [1:0] vel_prec);
		logic [KCONST_W-1:0] val;
		case (vel_prec)
			2'd0: val = KCONST_W'(64'd111194927);
			2'd1: val = KCONST_W'(64'd1111949270);
			2'd2: val = KCONST_W'(64'd11119492700);
			default: val = KCONST_W'(64'd111194927000);
		endcase
		return val;
	endfunction

endpackage

// ----- design/gfve_arith.sv -----
module gfve_arith #(
	parameter int MS_BITS = gfve_pkg::GFVE_MS_BITS
) (
	input  logic                                clk,
	input  gfve_pkg::arith_ctrl_t               ctrl,
	input  logic [MS_BITS-1:0]                  ms,
	output logic [gfve_pkg::QUOT_W-1:0]         quot,
	output logic                                ovf
);
	import gfve_pkg::*;

	localparam int DEN_W = POW10_W + MS_BITS;
	localparam int SHD_W = DEN_W + QUOT_W;
	localparam int CMP_W = (SHD_W > NUM_W) ? SHD_W : NUM_W;

	logic [KCONST_W-1:0] kconst;
	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic [63:0]         prod;
	logic [DEN_W-1:0]    den_q;
	logic [NUM_W-1:0]    rem_q;
	logic [QUOT_W-1:0]   quot_q;
	logic                ovf_q;
	logic [CMP_W-1:0]    rem_ext;
	logic [CMP_W-1:0]    den_sh;
	logic [CMP_W-1:0]    diff;
	logic                fits;

	assign kconst = gfve_kconst(ctrl.vel_prec);

	// Select the operands of the shared multiplier
	always_comb begin
		case (ctrl.op)
			OP_DEN: begin
				mul_a = 32'(gfve_pow10(ctrl.prec));
				mul_b = 32'(ms);
			end
			OP_MLO: begin
				mul_a = ctrl.mag;
				mul_b = kconst[31:0];
			end
			OP_MHI: begin
				mul_a = ctrl.mag;
				mul_b = 32'(kconst[KCONST_W-1:32]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// One restoring division step against the shifted denominator
	assign rem_ext = CMP_W'(rem_q);
	assign den_sh = CMP_W'(den_q) << ctrl.step;
	assign fits = (rem_ext >= den_sh);
	assign diff = rem_ext - den_sh;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_DEN: begin
				den_q <= DEN_W'(prod);
				quot_q <= '0;
				ovf_q <= 1'b0;
			end
			OP_MLO: begin
				rem_q <= NUM_W'(prod);
			end
			OP_MHI: begin
				rem_q <= rem_q + (NUM_W'(prod) << 32);
			end
			OP_DIV: begin
				if (fits) begin
					rem_q <= diff[NUM_W-1:0];
					// the top step only tells whether the quotient is out of range
					if (ctrl.step == 4'(QUOT_W))
						ovf_q <= 1'b1;
					else
						quot_q[ctrl.step[3:0]] <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign quot = quot_q;
	assign ovf = ovf_q;

endmodule

// ----- design/gps_fix_velocity_estimator_unit.sv -----
// GPS fix velocity estimator. A position fix that needs a velocity stalls the input
// after it is taken: per axis a state for the coordinate difference, three passes
// through a shared 32x32 multiplier (denominator, low and high halves of the numerator),
// sixteen restoring-division steps and one check, then a hand-over state for the result.
// The next item can be taken only once the result is handed over; the divider loop
// dominates. A restart is taken with no stall at all. A first (reference) fix or a
// zero-time fix goes straight to the hand-over state. The hand-over waits while the
// output register still holds an earlier result. in_stall is high while a fix is being
// worked on; one finished result can wait in the output register. Configuration writes
// are always ready and must only be made while the block is idle.
module gps_fix_velocity_estimator_unit #(
	parameter int MS_BITS = gfve_pkg::GFVE_MS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gfve_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output gfve_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [14:0]         cfg_data
);
	import gfve_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUB = 3'd1;
	localparam logic [2:0] ST_DEN = 3'd2;
	localparam logic [2:0] ST_MLO = 3'd3;
	localparam logic [2:0] ST_MHI = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_CHK = 3'd6;
	localparam logic [2:0] ST_FIN = 3'd7;

	logic [2:0]         state_q;
	logic [3:0]         lat_prec_q;
	logic [3:0]         lon_prec_q;
	logic [1:0]         vel_prec_q;
	logic [14:0]        vel_limit_q;
	logic               have_ref_q;
	logic [31:0]        ref_lat_q;
	logic [31:0]        ref_lon_q;
	logic [31:0]        cur_lat_q;
	logic [31:0]        cur_lon_q;
	logic [MS_BITS-1:0] ms_q;
	logic               axis_q;
	logic [3:0]         step_q;
	logic [31:0]        mag_q;
	logic               neg_q;
	logic [QUOT_W-1:0]  vn_q;
	logic               vn_neg_q;
	logic               over_q;
	out_item_t          res_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic               accept;
	logic               out_free;
	logic [31:0]        ms_ext;
	logic [MS_BITS-1:0] ms_in;
	logic [31:0]        cur_sel;
	logic [31:0]        ref_sel;
	logic signed [32:0] delta;
	logic [32:0]        delta_abs;
	arith_ctrl_t        actrl;
	logic [QUOT_W-1:0]  quot;
	logic               ovf;
	logic               over_now;
	logic               reject;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign ms_ext = 32'(in_data.elapsed_ms);
	assign ms_in = ms_ext[MS_BITS-1:0];

	// Coordinate difference of the axis being worked on
	assign cur_sel = axis_q ? cur_lon_q : cur_lat_q;
	assign ref_sel = axis_q ? ref_lon_q : ref_lat_q;
	assign delta = $signed({cur_sel[31], cur_sel}) - $signed({ref_sel[31], ref_sel});
	assign delta_abs = delta[32] ? 33'(-delta) : 33'(delta);

	// Drive the shared arithmetic unit from the sequencer state
	always_comb begin
		actrl.mag = mag_q;
		actrl.prec = axis_q ? lon_prec_q : lat_prec_q;
		actrl.vel_prec = vel_prec_q;
		actrl.step = step_q;
		case (state_q)
			ST_DEN: actrl.op = OP_DEN;
			ST_MLO: actrl.op = OP_MLO;
			ST_MHI: actrl.op = OP_MHI;
			ST_DIV: actrl.op = OP_DIV;
			default: actrl.op = OP_NONE;
		endcase
	end

	gfve_arith #(
		.MS_BITS(MS_BITS)
	) u_arith (
		.clk(clk),
		.ctrl(actrl),
		.ms(ms_q),
		.quot(quot),
		.ovf(ovf)
	);

	assign over_now = ovf || (quot > vel_limit_q);
	assign reject = over_now || over_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_prec_q <= 4'd7;
			lon_prec_q <= 4'd7;
			vel_prec_q <= 2'd2;
			vel_limit_q <= 15'd32767;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LAT_PREC: lat_prec_q <= cfg_data[3:0];
				REG_LON_PREC: lon_prec_q <= cfg_data[3:0];
				REG_VEL_PREC: vel_prec_q <= cfg_data[1:0];
				REG_VEL_LIMIT: vel_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer, reference and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_ref_q <= 1'b0;
			ref_lat_q <= '0;
			ref_lon_q <= '0;
			out_valid_q <= 1'b0;
			axis_q <= 1'b0;
			step_q <= '0;
		end else begin
			// drop the result once taken, unless a new one is handed over now
			if (out_valid_q && !out_stall && state_q != ST_FIN)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.kind) begin
							have_ref_q <= 1'b0;
						end else if (!have_ref_q) begin
							ref_lat_q <= in_data.latitude_raw;
							ref_lon_q <= in_data.longitude_raw;
							have_ref_q <= 1'b1;
							res_q <= '{north_velocity: '0, east_velocity: '0,
								rejected: 1'b0, reference_taken: 1'b1};
							state_q <= ST_FIN;
						end else if (ms_in == '0) begin
							have_ref_q <= 1'b0;
							res_q <= '{north_velocity: '0, east_velocity: '0,
								rejected: 1'b1, reference_taken: 1'b0};
							state_q <= ST_FIN;
						end else begin
							res_q <= '0;
							cur_lat_q <= in_data.latitude_raw;
							cur_lon_q <= in_data.longitude_raw;
							ms_q <= ms_in;
							axis_q <= 1'b0;
							over_q <= 1'b0;
							state_q <= ST_SUB;
						end
					end
				end
				ST_SUB: begin
					mag_q <= delta_abs[31:0];
					neg_q <= delta[32];
					state_q <= ST_DEN;
				end
				ST_DEN: state_q <= ST_MLO;
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: begin
					step_q <= 4'(QUOT_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0)
						state_q <= ST_CHK;
					else
						step_q <= step_q - 4'd1;
				end
				ST_CHK: begin
					if (!axis_q) begin
						// keep the north result and go on to the east axis
						vn_q <= quot;
						vn_neg_q <= neg_q;
						over_q <= over_now;
						axis_q <= 1'b1;
						state_q <= ST_SUB;
					end else begin
						if (reject) begin
							have_ref_q <= 1'b0;
							res_q.rejected <= 1'b1;
						end else begin
							res_q.north_velocity <= vn_neg_q ? -16'(vn_q) : 16'(vn_q);
							res_q.east_velocity <= neg_q ? -16'(quot) : 16'(quot);
							ref_lat_q <= cur_lat_q;
							ref_lon_q <= cur_lon_q;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						out_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
